@@ design/ffha_pkg.sv @@
// shared types, constants and helpers for the first-fit heap allocator
`default_nettype none

package ffha_pkg;

   // heap geometry
   localparam int HEAP_WORDS = 65536;
   localparam int OFS_W      = $clog2(HEAP_WORDS);
   localparam int SIZE_W     = $clog2(HEAP_WORDS + 1);
   localparam int STEP_W     = $clog2(HEAP_WORDS + 1);

   // field widths
   localparam int REQ_W  = 17;
   localparam int PTR_W  = 32;
   localparam int CALC_W = ((SIZE_W > REQ_W) ? SIZE_W : REQ_W) + 2;

   localparam int HDR_WORDS = 2;
   localparam int MIN_TAIL  = 3;
   localparam logic [PTR_W-1:0] BASE_RESET = 32'h0010_0000;

   // request commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ALLOC = 2'd0,
      STATUS_NOFIT = 2'd1,
      STATUS_ZERO  = 2'd2,
      STATUS_FREED = 2'd3
   } status_type;

   typedef struct packed {
      logic             cmd;
      logic [REQ_W-1:0] request_words;
      logic [PTR_W-1:0] block_pointer;
   } req_type;

   typedef struct packed {
      logic [PTR_W-1:0] result_pointer;
      status_type       status;
   } rsp_type;

   // block header: size in words (header included), link valid, link offset
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              link;
      logic [OFS_W-1:0]  next;
   } hdr_type;

   localparam hdr_type HDR_RESET = '{size: SIZE_W'(HEAP_WORDS), link: 1'b0, next: '0};

   typedef struct packed {
      logic             en;
      logic [OFS_W-1:0] addr;
      hdr_type          data;
   } hdr_wr_type;

   typedef struct packed {
      logic             en;
      logic [OFS_W-1:0] addr;
   } hdr_rd_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_RD_BLK,
      DP_LATCH_BLK,
      DP_RD_CUR,
      DP_LATCH_CUR,
      DP_ADVANCE,
      DP_WR_NB,
      DP_WR_PREV_ALLOC,
      DP_WR_CUR,
      DP_WR_BLK,
      DP_WR_PREV_FREE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic             is_free;
      logic             req_zero;
      logic             free_skip;
      logic             cur_ok;
      logic             steps_done;
      logic             fit;
      logic             cur_lt_blk;
      logic             cur_eq_blk;
      logic [PTR_W-1:0] alloc_ptr;
   } dp_stat_type;

   // size sum clamped to the heap length
   function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                 input logic [SIZE_W-1:0] b);
      logic [SIZE_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum > (SIZE_W + 1)'(HEAP_WORDS)) begin
         return SIZE_W'(HEAP_WORDS);
      end
      return sum[SIZE_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/ffha_hdr_store.sv @@
// header store: one header per heap word offset, registered read
`default_nettype none

module ffha_hdr_store
   import ffha_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  hdr_wr_type wr,
   input  hdr_rd_type rd,
   output hdr_type    rd_hdr
);

   hdr_type          mem [HEAP_WORDS];
   hdr_type          q_ff;
   logic [OFS_W-1:0] raddr_ff;
   logic             e0_written_ff;
   logic             e0_written_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         q_ff     <= mem[rd.addr];
         raddr_ff <= rd.addr;
      end
   end

   // entry 0 spans the whole heap until it is first written
   assign e0_written_in = e0_written_ff | (wr.en & (wr.addr == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_written_ff <= 1'b0;
      end else begin
         e0_written_ff <= e0_written_in;
      end
   end

   assign rd_hdr = ((raddr_ff == '0) && !e0_written_ff) ? HDR_RESET : q_ff;

endmodule

`default_nettype wire

@@ design/ffha_datapath.sv @@
// datapath: request, walk pointers, free list head and header updates
`default_nettype none

module ffha_datapath
   import ffha_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  req_type          req_data,
   input  wire              csr_wr_en,
   input  wire [PTR_W-1:0]  csr_wr_data,
   input  dp_cmd_type       cmd,
   output dp_stat_type      stat
);

   logic [PTR_W-1:0]  base_ff, base_in;
   logic [OFS_W-1:0]  head_ff, head_in;
   logic              head_ok_ff, head_ok_in;
   req_type           req_ff, req_in;
   logic [OFS_W-1:0]  cur_ff, cur_in;
   logic              cur_ok_ff, cur_ok_in;
   logic [OFS_W-1:0]  prev_ff, prev_in;
   logic              prev_ok_ff, prev_ok_in;
   hdr_type           prev_hdr_ff, prev_hdr_in;
   hdr_type           cur_hdr_ff, cur_hdr_in;
   logic [SIZE_W-1:0] blk_size_ff, blk_size_in;
   hdr_type           blk_fin_ff, blk_fin_in;
   logic [STEP_W-1:0] steps_ff, steps_in;

   hdr_wr_type        wr;
   hdr_rd_type        rd;
   hdr_type           rd_hdr;

   logic [PTR_W-1:0]  blk_full;
   logic [OFS_W-1:0]  blk;
   logic [CALC_W-1:0] total;
   logic [CALC_W-1:0] nb_sum;
   logic [CALC_W-1:0] nb_diff;
   logic [OFS_W-1:0]  nb_ofs;
   logic [SIZE_W-1:0] nb_size;
   logic              split;
   logic [OFS_W-1:0]  nxt;
   logic              nxt_ok;
   logic              merge_n;
   logic              merge_p;
   hdr_type           blk_fin;

   ffha_hdr_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd     (rd),
      .rd_hdr (rd_hdr)
   );

   // header offset of the block named by a free
   assign blk_full = req_ff.block_pointer - PTR_W'(HDR_WORDS) - base_ff;
   assign blk      = blk_full[OFS_W-1:0];

   assign total   = CALC_W'(req_ff.request_words) + CALC_W'(HDR_WORDS);
   assign nb_sum  = CALC_W'(cur_ff) + total;
   assign nb_diff = CALC_W'(cur_hdr_ff.size) - total;
   assign nb_ofs  = nb_sum[OFS_W-1:0];
   assign nb_size = nb_diff[SIZE_W-1:0];
   assign split   = (CALC_W'(cur_hdr_ff.size) >= total + CALC_W'(MIN_TAIL)) &&
                    (nb_sum < CALC_W'(HEAP_WORDS));
   assign nxt     = split ? nb_ofs : cur_hdr_ff.next;
   assign nxt_ok  = split | cur_hdr_ff.link;

   assign merge_n = cur_ok_ff &&
                    (CALC_W'(blk) + CALC_W'(blk_size_ff) == CALC_W'(cur_ff));
   assign merge_p = CALC_W'(prev_ff) + CALC_W'(prev_hdr_ff.size) == CALC_W'(blk);

   always_comb begin
      if (merge_n) begin
         blk_fin = '{size: sat_add(blk_size_ff, cur_hdr_ff.size),
                     link: cur_hdr_ff.link, next: cur_hdr_ff.next};
      end else begin
         blk_fin = '{size: blk_size_ff, link: cur_ok_ff, next: cur_ff};
      end
   end

   always_comb begin
      base_in     = base_ff;
      head_in     = head_ff;
      head_ok_in  = head_ok_ff;
      req_in      = req_ff;
      cur_in      = cur_ff;
      cur_ok_in   = cur_ok_ff;
      prev_in     = prev_ff;
      prev_ok_in  = prev_ok_ff;
      prev_hdr_in = prev_hdr_ff;
      cur_hdr_in  = cur_hdr_ff;
      blk_size_in = blk_size_ff;
      blk_fin_in  = blk_fin_ff;
      steps_in    = steps_ff;
      wr          = '0;
      rd          = '0;

      if (csr_wr_en) begin
         base_in = csr_wr_data;
      end

      unique case (cmd.op)
         DP_LOAD: begin
            req_in     = req_data;
            cur_in     = head_ff;
            cur_ok_in  = head_ok_ff;
            prev_ok_in = 1'b0;
            steps_in   = '0;
         end
         DP_RD_BLK: begin
            rd.en   = 1'b1;
            rd.addr = blk;
         end
         DP_LATCH_BLK: begin
            blk_size_in = rd_hdr.size;
         end
         DP_RD_CUR: begin
            rd.en   = 1'b1;
            rd.addr = cur_ff;
         end
         DP_LATCH_CUR: begin
            cur_hdr_in = rd_hdr;
         end
         DP_ADVANCE: begin
            prev_in     = cur_ff;
            prev_ok_in  = 1'b1;
            prev_hdr_in = rd_hdr;
            cur_in      = rd_hdr.next;
            cur_ok_in   = rd_hdr.link;
            steps_in    = steps_ff + STEP_W'(1);
         end
         DP_WR_NB: begin
            // tail of a split block becomes a new free block
            wr.en   = split;
            wr.addr = nb_ofs;
            wr.data = '{size: nb_size, link: cur_hdr_ff.link, next: cur_hdr_ff.next};
         end
         DP_WR_PREV_ALLOC: begin
            if (prev_ok_ff) begin
               wr.en   = 1'b1;
               wr.addr = prev_ff;
               wr.data = '{size: (split && (prev_ff == nb_ofs)) ? nb_size : prev_hdr_ff.size,
                           link: nxt_ok, next: nxt};
            end else begin
               head_in    = nxt;
               head_ok_in = nxt_ok;
            end
         end
         DP_WR_CUR: begin
            wr.en   = 1'b1;
            wr.addr = cur_ff;
            wr.data = '{size: split ? total[SIZE_W-1:0] : cur_hdr_ff.size,
                        link: 1'b0, next: '0};
         end
         DP_WR_BLK: begin
            wr.en      = 1'b1;
            wr.addr    = blk;
            wr.data    = blk_fin;
            blk_fin_in = blk_fin;
         end
         DP_WR_PREV_FREE: begin
            if (prev_ok_ff) begin
               wr.en   = 1'b1;
               wr.addr = prev_ff;
               if (merge_p) begin
                  wr.data = '{size: sat_add(prev_hdr_ff.size, blk_fin_ff.size),
                              link: blk_fin_ff.link, next: blk_fin_ff.next};
               end else begin
                  wr.data = '{size: prev_hdr_ff.size, link: 1'b1, next: blk};
               end
            end else begin
               head_in    = blk;
               head_ok_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BASE_RESET;
         head_ff    <= '0;
         head_ok_ff <= 1'b1;
      end else begin
         base_ff    <= base_in;
         head_ff    <= head_in;
         head_ok_ff <= head_ok_in;
      end
      req_ff      <= req_in;
      cur_ff      <= cur_in;
      cur_ok_ff   <= cur_ok_in;
      prev_ff     <= prev_in;
      prev_ok_ff  <= prev_ok_in;
      prev_hdr_ff <= prev_hdr_in;
      cur_hdr_ff  <= cur_hdr_in;
      blk_size_ff <= blk_size_in;
      blk_fin_ff  <= blk_fin_in;
      steps_ff    <= steps_in;
   end

   assign stat.is_free    = (req_ff.cmd == CMD_FREE);
   assign stat.req_zero   = (req_ff.request_words == '0);
   assign stat.free_skip  = (req_ff.block_pointer == '0) || (blk_full[PTR_W-1:OFS_W] != '0);
   assign stat.cur_ok     = cur_ok_ff;
   assign stat.steps_done = (steps_ff >= STEP_W'(HEAP_WORDS));
   assign stat.fit        = (CALC_W'(rd_hdr.size) >= total);
   assign stat.cur_lt_blk = (cur_ff < blk);
   assign stat.cur_eq_blk = (cur_ff == blk);
   assign stat.alloc_ptr  = base_ff + PTR_W'(cur_ff) + PTR_W'(HDR_WORDS);

endmodule

`default_nettype wire

@@ design/ffha_ctrl.sv @@
// controller: request sequencing, list walk steps and the result register
`default_nettype none

module ffha_ctrl
   import ffha_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output rsp_type     rsp_data,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_A_RD,
      S_A_EV,
      S_A_WNB,
      S_A_WPRV,
      S_A_WCUR,
      S_F_RDB,
      S_F_LDB,
      S_F_RD,
      S_F_EV,
      S_F_MN,
      S_F_MP,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       load;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd.op   = DP_NOP;
      load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.is_free) begin
               if (stat.free_skip) begin
                  code_in  = STATUS_FREED;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_F_RDB;
               end
            end else if (stat.req_zero) begin
               code_in  = STATUS_ZERO;
               state_in = S_FINISH;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_A_RD: begin
            if (!stat.cur_ok || stat.steps_done) begin
               code_in  = STATUS_NOFIT;
               state_in = S_FINISH;
            end else begin
               cmd.op   = DP_RD_CUR;
               state_in = S_A_EV;
            end
         end
         S_A_EV: begin
            if (stat.fit) begin
               cmd.op   = DP_LATCH_CUR;
               state_in = S_A_WNB;
            end else begin
               cmd.op   = DP_ADVANCE;
               state_in = S_A_RD;
            end
         end
         S_A_WNB: begin
            cmd.op   = DP_WR_NB;
            state_in = S_A_WPRV;
         end
         S_A_WPRV: begin
            cmd.op   = DP_WR_PREV_ALLOC;
            state_in = S_A_WCUR;
         end
         S_A_WCUR: begin
            cmd.op   = DP_WR_CUR;
            code_in  = STATUS_ALLOC;
            state_in = S_FINISH;
         end
         S_F_RDB: begin
            cmd.op   = DP_RD_BLK;
            state_in = S_F_LDB;
         end
         S_F_LDB: begin
            cmd.op   = DP_LATCH_BLK;
            state_in = S_F_RD;
         end
         S_F_RD: begin
            if (!stat.cur_ok) begin
               state_in = S_F_MN;
            end else begin
               cmd.op   = DP_RD_CUR;
               state_in = S_F_EV;
            end
         end
         S_F_EV: begin
            code_in = STATUS_FREED;
            if (stat.cur_lt_blk) begin
               if (stat.steps_done) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.op   = DP_ADVANCE;
                  state_in = S_F_RD;
               end
            end else if (stat.cur_eq_blk) begin
               // block already on the free list
               state_in = S_FINISH;
            end else begin
               cmd.op   = DP_LATCH_CUR;
               state_in = S_F_MN;
            end
         end
         S_F_MN: begin
            cmd.op   = DP_WR_BLK;
            state_in = S_F_MP;
         end
         S_F_MP: begin
            cmd.op   = DP_WR_PREV_FREE;
            code_in  = STATUS_FREED;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register frees the walk as soon as it is loaded
   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_data_in.result_pointer = (code_ff == STATUS_ALLOC) ? stat.alloc_ptr : '0;
         rsp_data_in.status         = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff     <= code_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ design/first_fit_heap_allocator_core.sv @@
// First-fit heap allocator with an address-sorted free list and coalescing.
//
// Requests arrive on req_valid/req_stall/req_data (allocate or free), one
// result per request leaves on rsp_valid/rsp_stall/rsp_data. A transfer takes
// place when valid is high and stall is low. heap_base is written through
// csr_wr_en/csr_wr_data; the user must do so only while no request is in
// flight, and the block does not enforce this. One request is worked on at a
// time. Each visited free block costs a header store read, then an evaluate
// step. A zero request or a null/out-of-heap free answers without a list
// walk. The store has one read and one write port. A new request is taken in
// the cycle after the previous result is loaded into the output register,
// even while that result is still stalled. A finished walk waits in its last
// state while an older stalled result holds the output register. Reset
// empties the output register, sets heap_base to 0x00100000 and turns the
// whole heap into one free block at offset 0; no clearing pass over the
// header store is needed.
`default_nettype none

module first_fit_heap_allocator_core
   import ffha_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output rsp_type          rsp_data,
   input  wire              csr_wr_en,
   input  wire [PTR_W-1:0]  csr_wr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

   ffha_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

`default_nettype wire

@@ design/ffha_checker.sv @@
// port-level checks for the allocator core, bound to the top level
`default_nettype none

module ffha_checker
   import ffha_pkg::*;
(
   input wire     clock,
   input wire     reset,
   input wire     req_valid,
   input wire     req_stall,
   input wire     rsp_valid,
   input wire     rsp_stall,
   input rsp_type rsp_data
);

   // output register is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // only a successful allocate carries a pointer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_ALLOC) |-> rsp_data.result_pointer == '0)
      else $error("non-null pointer without allocation");

   // one request at a time: busy right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_checker (.*);

`default_nettype wire

@@ test/first_fit_heap_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the first-fit heap allocator core
module first_fit_heap_allocator_core_tb;
   import ffha_pkg::*;

   // walks stay under about 50 headers, with random stalls and gaps plus long hold-offs
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_LIVE     = 48;
   localparam int PHASE_ITEMS  = 130;
   localparam int SETTINGS_N   = 6;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [PTR_W-1:0] csr_wr_data = '0;

   // heap state as the allocator should hold it, indexed by word offset
   logic [SIZE_W-1:0] blk_size   [HEAP_WORDS];
   logic [OFS_W-1:0]  blk_next   [HEAP_WORDS];
   logic              blk_linked [HEAP_WORDS];
   logic [OFS_W-1:0]  head_ofs;
   logic              head_valid;
   logic [PTR_W-1:0]  base_addr;

   req_type      pending_reqs [$];
   rsp_type      due_results  [$];
   int unsigned  live_ofs     [$];
   int unsigned  stale_ofs    [$];

   int unsigned  queued_count   = 0;
   int unsigned  accepted_count = 0;
   int unsigned  checked_count  = 0;
   int unsigned  error_count    = 0;
   int unsigned  cycle_count    = 0;
   int unsigned  base_writes    = 0;
   int unsigned  status_count [4];
   int unsigned  send_gap       = 0;
   int unsigned  stall_left     = 0;
   int unsigned  hold_left      = 0;
   int unsigned  hold_requests  = 0;
   int unsigned  hold_served    = 0;
   bit           hold_on        = 1'b0;
   bit           quiet_mode     = 1'b0;
   rsp_type      predicted_rsp;
   rsp_type      oldest_rsp;

   first_fit_heap_allocator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (quiet_mode || roll < 60) begin
         return 0;
      end
      if (roll < 93) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_at(int unsigned ofs);
      return base_addr + ofs + HDR_WORDS;
   endfunction

   function automatic logic [SIZE_W-1:0] merged_size(int unsigned a, int unsigned b);
      return (a + b > HEAP_WORDS) ? SIZE_W'(HEAP_WORDS) : SIZE_W'(a + b);
   endfunction

   function automatic void relink(bit has_prev, int unsigned prev, int unsigned to, bit to_ok);
      if (has_prev) begin
         blk_next[prev]   = OFS_W'(to);
         blk_linked[prev] = to_ok;
      end else begin
         head_ofs   = OFS_W'(to);
         head_valid = to_ok;
      end
   endfunction

   function automatic rsp_type first_fit_take(int unsigned words);
      rsp_type     r;
      int unsigned need, prev, cur, nxt, steps;
      bit          prev_ok, cur_ok, nxt_ok;
      need    = words + HDR_WORDS;
      prev    = 0;
      prev_ok = 1'b0;
      cur     = head_ofs;
      cur_ok  = head_valid;
      steps   = 0;
      r.result_pointer = '0;
      r.status         = STATUS_NOFIT;
      while (cur_ok && cur < HEAP_WORDS && steps < HEAP_WORDS) begin
         steps++;
         if (blk_size[cur] >= need) begin
            nxt    = blk_next[cur];
            nxt_ok = blk_linked[cur];
            // split off the tail only when it can hold a header and a word
            if (blk_size[cur] >= need + MIN_TAIL && cur + need < HEAP_WORDS) begin
               blk_size[cur + need]   = SIZE_W'(blk_size[cur] - need);
               blk_next[cur + need]   = blk_next[cur];
               blk_linked[cur + need] = blk_linked[cur];
               blk_size[cur]          = SIZE_W'(need);
               nxt    = cur + need;
               nxt_ok = 1'b1;
            end
            relink(prev_ok, prev, nxt, nxt_ok);
            blk_linked[cur]  = 1'b0;
            blk_next[cur]    = '0;
            r.result_pointer = ptr_at(cur);
            r.status         = STATUS_ALLOC;
            return r;
         end
         prev    = cur;
         prev_ok = 1'b1;
         cur_ok  = blk_linked[cur];
         cur     = blk_next[cur];
      end
      return r;
   endfunction

   function automatic void release_block(logic [PTR_W-1:0] ptr);
      int unsigned blk, prev, cur, steps;
      bit          prev_ok, cur_ok;
      if (ptr == '0) begin
         return;
      end
      blk = ptr - HDR_WORDS - base_addr;
      if (blk >= HEAP_WORDS) begin
         return;
      end
      prev    = 0;
      prev_ok = 1'b0;
      cur     = head_ofs;
      cur_ok  = head_valid;
      steps   = 0;
      while (cur_ok && cur < blk) begin
         if (steps >= HEAP_WORDS || cur >= HEAP_WORDS) begin
            return;
         end
         steps++;
         prev    = cur;
         prev_ok = 1'b1;
         cur_ok  = blk_linked[cur];
         cur     = blk_next[cur];
      end
      // already free: leave the list alone
      if (cur_ok && (cur == blk || cur >= HEAP_WORDS)) begin
         return;
      end
      blk_next[blk]   = OFS_W'(cur);
      blk_linked[blk] = cur_ok;
      relink(prev_ok, prev, blk, 1'b1);
      if (cur_ok && blk + blk_size[blk] == cur) begin
         blk_size[blk]   = merged_size(blk_size[blk], blk_size[cur]);
         blk_next[blk]   = blk_next[cur];
         blk_linked[blk] = blk_linked[cur];
      end
      if (prev_ok && prev + blk_size[prev] == blk) begin
         blk_size[prev]   = merged_size(blk_size[prev], blk_size[blk]);
         blk_next[prev]   = blk_next[blk];
         blk_linked[prev] = blk_linked[blk];
      end
   endfunction

   function automatic rsp_type heap_response(req_type item);
      rsp_type r;
      r.result_pointer = '0;
      if (item.cmd == CMD_FREE) begin
         release_block(item.block_pointer);
         r.status = STATUS_FREED;
      end else if (item.request_words == '0) begin
         r.status = STATUS_ZERO;
      end else begin
         r = first_fit_take(item.request_words);
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      // keep the log short on a badly broken block
      if (error_count <= 100) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // request side: present queued items with random gaps, predict on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_rsp = heap_response(req_data);
            due_results.push_back(predicted_rsp);
            status_count[predicted_rsp.status]++;
            if (predicted_rsp.status == STATUS_ALLOC) begin
               live_ofs.push_back(predicted_rsp.result_pointer - base_addr - HDR_WORDS);
            end
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         hold_on  <= 1'b0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            hold_on <= 1'b1;
         end else begin
            hold_on <= 1'b0;
         end
      end
   end

   // result side: random stalls, long hold-offs on request, field by field check
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing due: pointer %h status %0d",
                                         rsp_data.result_pointer, rsp_data.status));
            end else begin
               oldest_rsp = due_results.pop_front();
               if (rsp_data.result_pointer !== oldest_rsp.result_pointer) begin
                  report_mismatch($sformatf("result %0d pointer %h, wanted %h", checked_count,
                                            rsp_data.result_pointer, oldest_rsp.result_pointer));
               end
               if (rsp_data.status !== oldest_rsp.status) begin
                  report_mismatch($sformatf("result %0d status %0d, wanted %0d", checked_count,
                                            rsp_data.status, oldest_rsp.status));
               end
            end
            checked_count++;
         end
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  due_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic queue_request(logic cmd, int unsigned words, logic [PTR_W-1:0] ptr);
      req_type item;
      item.cmd           = cmd;
      item.request_words = REQ_W'(words);
      item.block_pointer = ptr;
      pending_reqs.push_back(item);
      queued_count++;
   endtask

   task automatic queue_alloc(int unsigned words);
      queue_request(CMD_ALLOC, words, $urandom());
   endtask

   task automatic queue_free(logic [PTR_W-1:0] ptr);
      queue_request(CMD_FREE, $urandom_range(HEAP_WORDS, 0), ptr);
   endtask

   task automatic wait_accepted();
      while (accepted_count != queued_count) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || due_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_heap_base(logic [PTR_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      base_addr = value;
      base_writes++;
   endtask

   function automatic int unsigned pick_words();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 70) begin
         return $urandom_range(32, 1);
      end
      if (roll < 90) begin
         return $urandom_range(1024, 33);
      end
      if (roll < 97) begin
         return $urandom_range(16384, 1025);
      end
      return $urandom_range(HEAP_WORDS, 16385);
   endfunction

   // mostly matched allocate/free traffic on live blocks, with a little noise
   task automatic run_random(int unsigned count);
      int unsigned      made, batch, k, roll, idx, ofs, hops;
      logic [PTR_W-1:0] p;
      made = 0;
      while (made < count) begin
         wait_accepted();
         batch = $urandom_range(8, 1);
         for (k = 0; k < batch; k++) begin
            roll = $urandom_range(99, 0);
            if (roll < 5) begin
               queue_alloc(0);
            end else if (roll < 10) begin
               case ($urandom_range(3, 0))
                  0: queue_free('0);
                  // header would sit one word below the heap
                  1: queue_free(base_addr + 1);
                  2: begin
                     p = $urandom();
                     while (p - HDR_WORDS - base_addr < HEAP_WORDS) begin
                        p = $urandom();
                     end
                     queue_free(p);
                  end
                  default: begin
                     // a block already on the free list, only while the list is settled
                     if (k == 0 && head_valid) begin
                        ofs  = head_ofs;
                        hops = $urandom_range(3, 0);
                        repeat (hops) begin
                           if (blk_linked[ofs]) begin
                              ofs = blk_next[ofs];
                           end
                        end
                        queue_free(ptr_at(ofs));
                     end else begin
                        queue_free('0);
                     end
                  end
               endcase
            end else if (live_ofs.size() > 0 && (roll < 50 || live_ofs.size() >= MAX_LIVE)) begin
               idx = $urandom_range(live_ofs.size() - 1, 0);
               ofs = live_ofs[idx];
               live_ofs.delete(idx);
               stale_ofs.push_back(ofs);
               queue_free(ptr_at(ofs));
            end else begin
               queue_alloc(pick_words());
            end
            made++;
         end
      end
   endtask

   initial begin
      logic [PTR_W-1:0] bases [SETTINGS_N];
      int unsigned      ph, idx, ofs;

      blk_size[0]   = SIZE_W'(HEAP_WORDS);
      blk_next[0]   = '0;
      blk_linked[0] = 1'b0;
      head_ofs      = '0;
      head_valid    = 1'b1;
      base_addr     = BASE_RESET;
      bases[0] = BASE_RESET;
      bases[1] = 32'h0000_0000;
      bases[2] = 32'hFFFF_FFFF;
      // offset 0 then maps to address 0, so its free looks like a null free
      bases[3] = 32'hFFFF_FFFE;
      bases[4] = $urandom();
      bases[5] = BASE_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, exact and near fits, every merge direction
      queue_alloc(0);
      queue_alloc(HEAP_WORDS);
      queue_alloc(HEAP_WORDS - 1);
      queue_alloc(HEAP_WORDS - 2);
      queue_alloc(1);
      queue_free('0);
      queue_free(ptr_at(0));
      queue_free(ptr_at(0));
      queue_free(base_addr + 1);
      queue_free(ptr_at(HEAP_WORDS));
      queue_free(32'hFFFF_FFFF);
      queue_alloc(1);
      queue_alloc(2);
      // leaves a two-word remainder, so the block goes out whole
      queue_alloc(HEAP_WORDS - 11);
      queue_free(ptr_at(3));
      queue_free(ptr_at(0));
      queue_free(ptr_at(7));
      // leaves exactly three words, which are split off
      queue_alloc(HEAP_WORDS - 5);
      queue_alloc(1);
      queue_free(ptr_at(HEAP_WORDS - 3));
      queue_free(ptr_at(0));
      wait_idle();
      live_ofs.delete();

      for (ph = 0; ph < SETTINGS_N; ph++) begin
         write_heap_base(bases[ph]);
         quiet_mode = (ph == 3);
         if (ph == 1) begin
            hold_requests++;
         end
         run_random(PHASE_ITEMS);
      end
      quiet_mode = 1'b0;

      // closing sweep: stale pointers freed again, then every live block, no more allocations
      wait_accepted();
      repeat (8) begin
         if (stale_ofs.size() > 0) begin
            idx = $urandom_range(stale_ofs.size() - 1, 0);
            queue_free(ptr_at(stale_ofs[idx]));
         end
         queue_alloc(0);
      end
      while (live_ofs.size() > 0) begin
         idx = $urandom_range(live_ofs.size() - 1, 0);
         ofs = live_ofs[idx];
         live_ofs.delete(idx);
         queue_free(ptr_at(ofs));
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d requests under %0d heap base settings, incl. long output hold-off",
               checked_count, base_writes);
      $display("outcomes: %0d granted, %0d no fit, %0d zero size, %0d frees",
               status_count[STATUS_ALLOC], status_count[STATUS_NOFIT],
               status_count[STATUS_ZERO], status_count[STATUS_FREED]);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
